// ===== hw/rtl/dtpy_pkg.sv =====
// Package with shared types, constants and the arctangent table for direction_to_pitch_yaw.
package dtpy_pkg;

  // Number of CORDIC stages in each vectoring pass (at most 32).
  localparam int CordicStages = 24;
  localparam int NStg = (CordicStages > 32) ? 32 : CordicStages;

  // Fixed-point constants.
  localparam int                 PreShift  = 26;
  localparam logic [30:0]        GainQ30   = 31'd1768195363;
  localparam logic [29:0]        Rad2DegQ24 = 30'd961263669;
  localparam logic signed [28:0] Deg90     = 29'sd5898240;
  localparam logic signed [28:0] Deg180    = 29'sd11796480;
  localparam logic signed [28:0] Deg360    = 29'sd23592960;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgPitchLimit  = 1'b0,
    CfgRecoilScale = 1'b1
  } cfg_idx_e;

  // Arctangent table, Q32 radians.
  typedef logic signed [35:0] atan_tab_t [32];

  // Entry 0 is pi/4; entry i is atan(2^-i) rounded to the nearest Q32 step.
  // From entry 11 onwards the cubic term is below half a step, so each entry is 2^(32-i).
  localparam atan_tab_t AtanTab = '{
    36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
    36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
    36'sd16777131,   36'sd8388597,    36'sd4194303,    36'sd2097152,
    36'sd1048576,    36'sd524288,     36'sd262144,     36'sd131072,
    36'sd65536,      36'sd32768,      36'sd16384,      36'sd8192,
    36'sd4096,       36'sd2048,       36'sd1024,       36'sd512,
    36'sd256,        36'sd128,        36'sd64,         36'sd32,
    36'sd16,         36'sd8,          36'sd4,          36'sd2
  };

  // Values that travel alongside the CORDIC data.
  typedef struct packed {
    logic               dx_neg;
    logic               dx_zero;
    logic               dy_pos;
    logic               degen;
    logic               dz_pos;
    logic               dz_zero;
    logic signed [59:0] zp;
    logic signed [27:0] rsp;
    logic signed [27:0] rsy;
    logic signed [35:0] a1;
  } side_t;

  // One CORDIC word: vector, accumulated angle and sideband.
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [35:0] z;
    side_t              side;
  } cw_t;

endpackage

// ===== hw/rtl/dtpy_if.sv =====
// Interfaces for the input and output transaction channels.
interface dtpy_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;
  logic signed [31:0] src_z;
  logic signed [31:0] dst_x;
  logic signed [31:0] dst_y;
  logic signed [31:0] dst_z;
  logic signed [23:0] recoil_pitch;
  logic signed [23:0] recoil_yaw;

  modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z,
                  recoil_pitch, recoil_yaw, input ready);
  modport sink (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z,
                recoil_pitch, recoil_yaw, output ready);
endinterface

interface dtpy_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] pitch;
  logic signed [24:0] yaw;
  logic               degenerate;

  modport source (output valid, pitch, yaw, degenerate, input ready);
  modport sink (input valid, pitch, yaw, degenerate, output ready);
endinterface

// ===== hw/rtl/dtpy_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation and its pipeline register.
module dtpy_cell
  import dtpy_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [4:0] stage_i,
  input  logic       valid_i,
  input  cw_t        d_i,
  output logic       valid_o,
  output cw_t        d_o
);

  logic valid_q;
  cw_t  d_d, d_q;
  logic signed [63:0] xs, ys;

  // Rotate towards the x axis, steering by the sign of y.
  always_comb begin
    xs = d_i.x >>> stage_i;
    ys = d_i.y >>> stage_i;
    d_d = d_i;
    if (!d_i.y[63]) begin
      d_d.x = d_i.x + ys;
      d_d.y = d_i.y - xs;
      d_d.z = d_i.z + AtanTab[stage_i];
    end else begin
      d_d.x = d_i.x - ys;
      d_d.y = d_i.y + xs;
      d_d.z = d_i.z - AtanTab[stage_i];
    end
  end

  // Valid flag of this stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Data register.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

// ===== hw/rtl/direction_to_pitch_yaw_core.sv =====
// Top level: direction to pitch and yaw angles through two chains of CORDIC cells.
//
// The block accepts one transaction per cycle while the pipeline advances, and returns
// one result for each, in order. Stages A and B form the deltas and the scaled dz term,
// NStg cells form the yaw pass, NStg cells the pitch pass, stages D1 and D2 turn radians
// into degrees and add recoil, and the clamping output register comes last.
// The whole pipeline moves forward whenever the output register is empty or being taken,
// so input ready is high under the same condition. Configuration writes take effect at once and
// should be made while no transaction is in flight.
module direction_to_pitch_yaw_core
  import dtpy_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dtpy_in_if.sink    in_s,
  dtpy_out_if.source out_s,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [6:0] cfg_wdata_i
);

  logic       adv;
  logic [6:0] pitch_limit_q;
  logic [2:0] recoil_scale_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_limit_q  <= 7'd89;
      recoil_scale_q <= 3'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPitchLimit:  pitch_limit_q  <= cfg_wdata_i;
        CfgRecoilScale: recoil_scale_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_s.valid || out_s.ready;
  assign in_s.ready = adv;

  // Stage A: deltas.
  logic               va_q;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [23:0] rp_q, ry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= 33'(in_s.src_x) - 33'(in_s.dst_x);
      dy_q <= 33'(in_s.src_y) - 33'(in_s.dst_y);
      dz_q <= 33'(in_s.src_z) - 33'(in_s.dst_z);
      rp_q <= in_s.recoil_pitch;
      ry_q <= in_s.recoil_yaw;
    end
  end

  // Stage B: pre-shifted start vector, gain-scaled dz and scaled recoil.
  logic               vb_q;
  cw_t                b_d, b_q;
  logic signed [63:0] dx_w, dy_w, zprod;

  always_comb begin
    dx_w  = 64'(dx_q);
    dy_w  = 64'(dy_q);
    zprod = dz_q * $signed({1'b0, GainQ30});
    b_d.x = (dx_q[32] ? -dx_w : dx_w) <<< PreShift;
    b_d.y = (dx_q[32] ? -dy_w : dy_w) <<< PreShift;
    b_d.z = '0;
    b_d.side.dx_neg  = dx_q[32];
    b_d.side.dx_zero = (dx_q == '0);
    b_d.side.dy_pos  = !dy_q[32] && (dy_q != '0);
    b_d.side.degen   = (dx_q == '0) && (dy_q == '0);
    b_d.side.dz_pos  = !dz_q[32] && (dz_q != '0);
    b_d.side.dz_zero = (dz_q == '0);
    b_d.side.zp      = 60'(zprod >>> (30 - PreShift));
    b_d.side.rsp     = 28'(rp_q * $signed({1'b0, recoil_scale_q}));
    b_d.side.rsy     = 28'(ry_q * $signed({1'b0, recoil_scale_q}));
    b_d.side.a1      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q <= b_d;
    end
  end

  // Yaw pass and pitch pass, each a chain of NStg cells.
  logic v1 [NStg+1];
  cw_t  c1 [NStg+1];
  logic v2 [NStg+1];
  cw_t  c2 [NStg+1];

  assign v1[0] = vb_q;
  assign c1[0] = b_q;

  // The pitch pass starts on the yaw pass magnitude and the scaled dz.
  always_comb begin
    v2[0]         = v1[NStg];
    c2[0]         = c1[NStg];
    c2[0].y       = 64'(c1[NStg].side.zp);
    c2[0].z       = '0;
    c2[0].side.a1 = c1[NStg].z;
  end

  for (genvar i = 0; i < NStg; i++) begin : g_cells
    dtpy_cell u_yaw (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (5'(i)),
      .valid_i (v1[i]),
      .d_i     (c1[i]),
      .valid_o (v1[i+1]),
      .d_o     (c1[i+1])
    );
    dtpy_cell u_pitch (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (5'(i)),
      .valid_i (v2[i]),
      .d_i     (c2[i]),
      .valid_o (v2[i+1]),
      .d_o     (c2[i+1])
    );
  end

  // Stage D1: magnitudes times the radians-to-degrees factor.
  logic        vd1_q;
  side_t       s1_q;
  logic        pneg_q, yneg_q;
  logic [65:0] pprod_q, yprod_q;
  logic [35:0] pmag, ymag;
  cw_t         e;

  always_comb begin
    e    = c2[NStg];
    pmag = e.z[35] ? 36'(-e.z) : 36'(e.z);
    ymag = e.side.a1[35] ? 36'(-e.side.a1) : 36'(e.side.a1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd1_q <= 1'b0;
    end else if (adv) begin
      vd1_q <= v2[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= e.side;
      pneg_q  <= e.z[35];
      yneg_q  <= e.side.a1[35];
      pprod_q <= 66'(pmag) * 66'(Rad2DegQ24);
      yprod_q <= 66'(ymag) * 66'(Rad2DegQ24);
    end
  end

  // Stage D2: round to Q9.16 degrees, apply special cases and recoil, add 180 to yaw unless dx < 0.
  logic               vd2_q;
  logic               degen_q, pnan_q;
  logic signed [28:0] praw_q, yraw_q;
  logic signed [28:0] pdeg, ydeg, pr, yr;

  always_comb begin
    pr   = 29'((pprod_q + (66'd1 << 39)) >> 40);
    yr   = 29'((yprod_q + (66'd1 << 39)) >> 40);
    pdeg = pneg_q ? -pr : pr;
    ydeg = yneg_q ? -yr : yr;
    if (s1_q.degen) begin
      pdeg = s1_q.dz_pos ? Deg90 : -Deg90;
    end
    if (s1_q.dx_zero) begin
      ydeg = s1_q.dy_pos ? Deg90 : -Deg90;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd2_q <= 1'b0;
    end else if (adv) begin
      vd2_q <= vd1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      degen_q <= s1_q.degen;
      pnan_q  <= s1_q.degen && s1_q.dz_zero;
      praw_q  <= pdeg - 29'(s1_q.rsp);
      yraw_q  <= ydeg - 29'(s1_q.rsy) + (s1_q.dx_neg ? 29'sd0 : Deg180);
    end
  end

  // Output register: pitch clamp, yaw wrap and zeroing of degenerate results.
  logic               vo_q;
  logic signed [28:0] lim, pc, yc;
  logic signed [24:0] pitch_q, yaw_q;
  logic               degen_o_q;

  always_comb begin
    lim = 29'(pitch_limit_q) <<< 16;
    pc  = praw_q;
    if (pc > lim && pc <= Deg180) pc = lim;
    if (pc > Deg180) pc = pc - Deg360;
    if (pc < -lim) pc = -lim;
    if (pc > Deg180) pc = Deg180;
    if (pc < -Deg180) pc = -Deg180;
    if (pnan_q) pc = '0;
    yc = yraw_q;
    if (yc > Deg180) yc = yc - Deg360;
    if (yc < -Deg180) yc = yc + Deg360;
    if (yc > Deg180) yc = Deg180;
    if (yc < -Deg180) yc = -Deg180;
    if (degen_q) yc = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= vd2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pitch_q   <= 25'(pc);
      yaw_q     <= 25'(yc);
      degen_o_q <= degen_q;
    end
  end

  assign out_s.valid      = vo_q;
  assign out_s.pitch      = pitch_q;
  assign out_s.yaw        = yaw_q;
  assign out_s.degenerate = degen_o_q;

endmodule

// ===== hw/rtl/dtpy_checker.sv =====
// Port-level checker for direction_to_pitch_yaw_core and its bind statement.
module dtpy_checker
  import dtpy_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [24:0] pitch_i,
  input logic signed [24:0] yaw_i,
  input logic               degenerate_i
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // An empty output stage never blocks the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // A degenerate direction has zero yaw.
  a_degen_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> yaw_i == '0)
    else $error("degenerate result with nonzero yaw");

  // Pitch stays within plus or minus 180 degrees.
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pitch_i <= 25'(Deg180)) && (pitch_i >= -25'(Deg180)))
    else $error("pitch out of range");

endmodule

bind direction_to_pitch_yaw_core dtpy_checker u_dtpy_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_s.ready),
  .out_valid_i  (out_s.valid),
  .out_ready_i  (out_s.ready),
  .pitch_i      (out_s.pitch),
  .yaw_i        (out_s.yaw),
  .degenerate_i (out_s.degenerate)
);
